>>> rtl/core/fcgp_pkg.sv
// ----------------------------------------------------------------------------
// fcgp_pkg
// shared types, constants and coefficient helpers of the fern plotter
// ----------------------------------------------------------------------------
package fcgp_pkg;

  // default parameter values
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // fixed field widths
  localparam int CFG_W  = 11;
  localparam int RAND_W = 16;
  localparam int PIX_W  = 10;
  localparam int MAP_W  = 2;

  // configuration reset values
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(800);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1000);

  // depth of the queues between the parts
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 8;

  // cumulative thresholds: r*100 <= cum*65535 is r <= floor(cum*65535/100)
  localparam logic [RAND_W-1:0] TH_MAIN  = RAND_W'((85 * 65535) / 100);
  localparam logic [RAND_W-1:0] TH_LEFT  = RAND_W'((92 * 65535) / 100);
  localparam logic [RAND_W-1:0] TH_RIGHT = RAND_W'((99 * 65535) / 100);

  typedef enum logic [MAP_W-1:0] {
    MAP_MAIN  = 2'd0,
    MAP_LEFT  = 2'd1,
    MAP_RIGHT = 2'd2,
    MAP_STEM  = 2'd3
  } map_t;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_SUM  = 1'b1
  } step_state_t;

  // new point strobe from the step engine to the pixel pipeline
  typedef struct packed {
    logic valid;
    map_t map;
  } pt_ctl_t;

  // one result item
  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             in_frame;
    map_t             map;
  } pix_t;

  // map coefficients in hundredths (x offset is zero for every map)
  localparam int COEF_A [4] = '{85, 20, -15, 0};
  localparam int COEF_B [4] = '{4, -26, 28, 0};
  localparam int COEF_C [4] = '{-4, 23, 26, 0};
  localparam int COEF_D [4] = '{85, 22, 24, 16};
  localparam int COEF_F [4] = '{160, 160, 44, 0};

  // hundredths to fixed point, rounded half away from zero
  function automatic longint fix_coef(input int hund, input int fb);
    longint s;
    longint m;
    longint q;
    s = longint'(hund) * (longint'(1) << fb);
    m = (s < 0) ? -s : s;
    q = (m + 50) / 100;
    return (s < 0) ? -q : q;
  endfunction

endpackage

>>> rtl/core/fcgp_fifo.sv
// ----------------------------------------------------------------------------
// fcgp_fifo
// small first-in first-out queue with show-ahead read
// ----------------------------------------------------------------------------
module fcgp_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  output logic [DW-1:0] rd_data,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + NW'(do_wr) - NW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/fcgp_front.sv
// ----------------------------------------------------------------------------
// fcgp_front
// input side: picks the fern map for each random value and queues it
// ----------------------------------------------------------------------------
module fcgp_front
  import fcgp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [RAND_W-1:0] in_random_fraction,
  output logic              in_full,
  input  logic              cmd_pop,
  output logic              cmd_valid,
  output map_t              cmd_map
);

  map_t             sel;
  logic             cmd_empty;
  logic [MAP_W-1:0] cmd_data;

  // first map whose cumulative threshold covers the value
  always_comb begin
    if (in_random_fraction <= TH_MAIN) begin
      sel = MAP_MAIN;
    end else if (in_random_fraction <= TH_LEFT) begin
      sel = MAP_LEFT;
    end else if (in_random_fraction <= TH_RIGHT) begin
      sel = MAP_RIGHT;
    end else begin
      sel = MAP_STEM;
    end
  end

  fcgp_fifo #(
    .DW    (MAP_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (sel),
    .rd_en   (cmd_pop),
    .rd_data (cmd_data),
    .full    (in_full),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;
  assign cmd_map   = map_t'(cmd_data);

endmodule

>>> rtl/core/fcgp_step.sv
// ----------------------------------------------------------------------------
// fcgp_step
// point recurrence: multiply cycle, then sum, round and saturate cycle
// ----------------------------------------------------------------------------
module fcgp_step
  import fcgp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  map_t                      cmd_map,
  output logic                      cmd_pop,
  input  logic                      out_take,
  output pt_ctl_t                   pt_ctl,
  output logic signed [FRAC_BITS+5:0] pt_x,
  output logic signed [FRAC_BITS+5:0] pt_y
);

  localparam int PB  = FRAC_BITS + 6;
  localparam int CW  = FRAC_BITS + 2;
  localparam int PW  = PB + CW;
  localparam int SW  = PW + 2;
  localparam int SHW = SW - FRAC_BITS;
  localparam int RW  = $clog2(OUT_DEPTH + 1);

  localparam logic signed [CW-1:0] TAB_A [4] = '{
    CW'(fix_coef(COEF_A[0], FRAC_BITS)), CW'(fix_coef(COEF_A[1], FRAC_BITS)),
    CW'(fix_coef(COEF_A[2], FRAC_BITS)), CW'(fix_coef(COEF_A[3], FRAC_BITS))};
  localparam logic signed [CW-1:0] TAB_B [4] = '{
    CW'(fix_coef(COEF_B[0], FRAC_BITS)), CW'(fix_coef(COEF_B[1], FRAC_BITS)),
    CW'(fix_coef(COEF_B[2], FRAC_BITS)), CW'(fix_coef(COEF_B[3], FRAC_BITS))};
  localparam logic signed [CW-1:0] TAB_C [4] = '{
    CW'(fix_coef(COEF_C[0], FRAC_BITS)), CW'(fix_coef(COEF_C[1], FRAC_BITS)),
    CW'(fix_coef(COEF_C[2], FRAC_BITS)), CW'(fix_coef(COEF_C[3], FRAC_BITS))};
  localparam logic signed [CW-1:0] TAB_D [4] = '{
    CW'(fix_coef(COEF_D[0], FRAC_BITS)), CW'(fix_coef(COEF_D[1], FRAC_BITS)),
    CW'(fix_coef(COEF_D[2], FRAC_BITS)), CW'(fix_coef(COEF_D[3], FRAC_BITS))};
  // y offset already scaled to the product's fraction
  localparam logic signed [SW-1:0] TAB_F [4] = '{
    SW'(fix_coef(COEF_F[0], FRAC_BITS) <<< FRAC_BITS),
    SW'(fix_coef(COEF_F[1], FRAC_BITS) <<< FRAC_BITS),
    SW'(fix_coef(COEF_F[2], FRAC_BITS) <<< FRAC_BITS),
    SW'(fix_coef(COEF_F[3], FRAC_BITS) <<< FRAC_BITS)};

  localparam logic signed [SW-1:0]  ROUND  = SW'(longint'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [SHW-1:0] SAT_HI = SHW'((longint'(1) <<< (PB - 1)) - 1);
  localparam logic signed [SHW-1:0] SAT_LO = SHW'(-(longint'(1) <<< (PB - 1)));

  step_state_t            state_r, state_nxt;
  logic signed [PB-1:0]   x_r, x_nxt;
  logic signed [PB-1:0]   y_r, y_nxt;
  logic signed [PW-1:0]   pa_r, pa_nxt;
  logic signed [PW-1:0]   pb_r, pb_nxt;
  logic signed [PW-1:0]   pc_r, pc_nxt;
  logic signed [PW-1:0]   pd_r, pd_nxt;
  map_t                   sel_r, sel_nxt;
  logic                   pt_valid_r, pt_valid_nxt;
  logic [RW-1:0]          reserved_r, reserved_nxt;
  logic                   credit_ok;
  logic signed [SW-1:0]   sum_x, sum_y;

  // floor to the point fraction, then clamp to the point range
  function automatic logic signed [PB-1:0] sat_pt(input logic signed [SW-1:0] s);
    logic signed [SHW-1:0] f;
    f = s[SW-1:FRAC_BITS];
    if (f > SAT_HI) begin
      return SAT_HI[PB-1:0];
    end else if (f < SAT_LO) begin
      return SAT_LO[PB-1:0];
    end
    return f[PB-1:0];
  endfunction

  // results in flight or waiting, so the pixel pipeline never has to stall
  assign credit_ok = (reserved_r < RW'(OUT_DEPTH));

  assign sum_x = SW'(pa_r) + SW'(pb_r) + ROUND;
  assign sum_y = SW'(pc_r) + SW'(pd_r) + TAB_F[sel_r] + ROUND;

  always_comb begin
    state_nxt    = state_r;
    cmd_pop      = 1'b0;
    x_nxt        = x_r;
    y_nxt        = y_r;
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    pc_nxt       = pc_r;
    pd_nxt       = pd_r;
    sel_nxt      = sel_r;
    pt_valid_nxt = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (cmd_valid && credit_ok) begin
          cmd_pop   = 1'b1;
          pa_nxt    = TAB_A[cmd_map] * x_r;
          pb_nxt    = TAB_B[cmd_map] * y_r;
          pc_nxt    = TAB_C[cmd_map] * x_r;
          pd_nxt    = TAB_D[cmd_map] * y_r;
          sel_nxt   = cmd_map;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        x_nxt        = sat_pt(sum_x);
        y_nxt        = sat_pt(sum_y);
        pt_valid_nxt = 1'b1;
        state_nxt    = ST_LOAD;
      end
    endcase
    reserved_nxt = reserved_r + RW'(cmd_pop) - RW'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      x_r        <= '0;
      y_r        <= '0;
      pt_valid_r <= 1'b0;
      reserved_r <= '0;
    end else begin
      state_r    <= state_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      pt_valid_r <= pt_valid_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    pc_r  <= pc_nxt;
    pd_r  <= pd_nxt;
    sel_r <= sel_nxt;
  end

  assign pt_ctl.valid = pt_valid_r;
  assign pt_ctl.map   = sel_r;
  assign pt_x         = x_r;
  assign pt_y         = y_r;

endmodule

>>> rtl/core/fcgp_pixel.sv
// ----------------------------------------------------------------------------
// fcgp_pixel
// projects each new point to a pixel and queues the results
// ----------------------------------------------------------------------------
module fcgp_pixel
  import fcgp_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pt_ctl_t                     pt_ctl,
  input  logic signed [FRAC_BITS+5:0] pt_x,
  input  logic signed [FRAC_BITS+5:0] pt_y,
  input  logic [CFG_W-1:0]            image_width,
  input  logic [CFG_W-1:0]            image_height,
  input  logic                        out_pop,
  output pix_t                        out_item,
  output logic                        out_empty
);

  localparam int PB  = FRAC_BITS + 6;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CPW = PB + WW + 2;
  localparam int RPW = PB + HW + 1;
  localparam int TCW = CPW - FRAC_BITS - 1;
  localparam int TRW = RPW - FRAC_BITS - 1;

  localparam logic signed [PB:0]    THREE = (PB + 1)'(longint'(3) <<< FRAC_BITS);
  // reciprocals, error of at most one below the true quotient
  localparam logic [TCW-1:0] RECIP3 = TCW'((longint'(1) << TCW) / 3);
  localparam logic [TRW-1:0] RECIP5 = TRW'((longint'(1) << TRW) / 5);

  logic [WW-1:0]          w_eff;
  logic [HW-1:0]          h_eff;

  // stage a: scaled numerators
  logic                   va_r;
  map_t                   mapa_r;
  logic signed [CPW-1:0]  colp_r;
  logic signed [RPW-1:0]  rowp_r;
  logic signed [PB:0]     xs;

  // stage b: magnitudes with the power-of-two part divided out
  logic                   vb_r;
  map_t                   mapb_r;
  logic                   negc_b_r, negr_b_r;
  logic [TCW-1:0]         tc_b_r;
  logic [TRW-1:0]         tr_b_r;
  logic [CPW-1:0]         mag_c;
  logic [RPW-1:0]         mag_r;

  // stage c: estimated quotients
  logic                   vc_r;
  map_t                   mapc_r;
  logic                   negc_c_r, negr_c_r;
  logic [TCW-1:0]         tc_c_r, qc0_r;
  logic [TRW-1:0]         tr_c_r, qr0_r;
  logic [2*TCW-1:0]       prod_c;
  logic [2*TRW-1:0]       prod_r;

  // final correction
  logic [TCW-1:0]         rem_c, qc;
  logic [TRW-1:0]         rem_r, qr;
  logic                   in_c, in_r;
  pix_t                   res;

  assign w_eff = (32'(image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(image_width);
  assign h_eff = (32'(image_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(image_height);

  assign xs = (PB + 1)'(pt_x) + THREE;

  always_ff @(posedge clk) begin
    colp_r <= xs * $signed({1'b0, w_eff});
    rowp_r <= pt_y * $signed({1'b0, h_eff});
    mapa_r <= pt_ctl.map;
  end

  assign mag_c = (colp_r < 0) ? CPW'(-colp_r) : CPW'(colp_r);
  assign mag_r = (rowp_r < 0) ? RPW'(-rowp_r) : RPW'(rowp_r);

  // column divisor is 3 * 2^(FRAC_BITS+1), row divisor 5 * 2^(FRAC_BITS+1)
  always_ff @(posedge clk) begin
    negc_b_r <= (colp_r < 0);
    negr_b_r <= (rowp_r < 0);
    tc_b_r   <= mag_c[CPW-1:FRAC_BITS+1];
    tr_b_r   <= mag_r[RPW-1:FRAC_BITS+1];
    mapb_r   <= mapa_r;
  end

  assign prod_c = tc_b_r * RECIP3;
  assign prod_r = tr_b_r * RECIP5;

  always_ff @(posedge clk) begin
    negc_c_r <= negc_b_r;
    negr_c_r <= negr_b_r;
    tc_c_r   <= tc_b_r;
    tr_c_r   <= tr_b_r;
    qc0_r    <= prod_c[2*TCW-1:TCW];
    qr0_r    <= prod_r[2*TRW-1:TRW];
    mapc_r   <= mapb_r;
  end

  always_comb begin
    rem_c = tc_c_r - TCW'(qc0_r * TCW'(3));
    rem_r = tr_c_r - TRW'(qr0_r * TRW'(5));
    qc    = qc0_r + TCW'(rem_c >= TCW'(3));
    qr    = qr0_r + TRW'(rem_r >= TRW'(5));
    // a small negative numerator truncates to zero, which is still on screen
    in_c  = (!negc_c_r || (qc == '0)) && (qc < TCW'(w_eff));
    in_r  = (!negr_c_r || (qr == '0)) && (qr < TRW'(h_eff));
    res.in_frame = in_c && in_r;
    res.col      = res.in_frame ? qc[PIX_W-1:0] : '0;
    res.row      = res.in_frame ? qr[PIX_W-1:0] : '0;
    res.map      = mapc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= pt_ctl.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  fcgp_fifo #(
    .DW    ($bits(pix_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (vc_r),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .full    (),
    .empty   (out_empty)
  );

endmodule

>>> rtl/core/fern_chaos_game_plotter.sv
// ----------------------------------------------------------------------------
// fern_chaos_game_plotter
// chaos-game step engine for the four-map fern with pixel projection
// ----------------------------------------------------------------------------
// Each 16-bit random value pushed in selects one of the four fern maps
// (cumulative odds 0.85 / 0.92 / 0.99 / 1.0), the map is applied to the
// running point (signed, FRAC_BITS fraction bits, starting at the origin
// after reset) and one result is queued: the pixel column and row of the new
// point, an on-screen flag and the map index. Column and row read zero when
// the pixel is off screen. An item is not started before the last one is
// through the point recurrence: a multiply step and a sum/round/saturate
// step that must finish before the next item can use the point.
// A two-entry queue holds classified items ahead of the step engine, and an
// eight-entry result queue sits behind the projection pipeline; the step
// engine only starts an item when a result slot is free, so results are
// never dropped while pop is held low. The user must write width and height
// through the cfg port only while the block is idle; the block itself does
// not enforce it.
module fern_chaos_game_plotter
  import fcgp_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input item channel
  input  logic              in_push,
  output logic              in_full,
  input  logic [RAND_W-1:0] in_random_fraction,
  // result channel
  output logic              out_empty,
  input  logic              out_pop,
  output logic [PIX_W-1:0]  out_pixel_column,
  output logic [PIX_W-1:0]  out_pixel_row,
  output logic              out_inside_res,
  output logic [MAP_W-1:0]  out_chosen_map,
  // configuration write port
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [CFG_W-1:0]            width_r, width_nxt;
  logic [CFG_W-1:0]            height_r, height_nxt;
  logic                        cmd_valid;
  logic                        cmd_pop;
  map_t                        cmd_map;
  logic                        out_take;
  pt_ctl_t                     pt_ctl;
  logic signed [FRAC_BITS+5:0] pt_x;
  logic signed [FRAC_BITS+5:0] pt_y;
  pix_t                        out_item;

  // configuration registers
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  width_nxt  = cfg_wdata;
        CFG_HEIGHT: height_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // result transfer frees a slot for the step engine's credit count
  assign out_take = out_pop && !out_empty;

  // front: map selection and command queue
  fcgp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_random_fraction (in_random_fraction),
    .in_full            (in_full),
    .cmd_pop            (cmd_pop),
    .cmd_valid          (cmd_valid),
    .cmd_map            (cmd_map)
  );

  // back: affine step on the running point
  fcgp_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_map   (cmd_map),
    .cmd_pop   (cmd_pop),
    .out_take  (out_take),
    .pt_ctl    (pt_ctl),
    .pt_x      (pt_x),
    .pt_y      (pt_y)
  );

  // trailing projection pipeline and result queue
  fcgp_pixel #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pixel (
    .clk          (clk),
    .rst_n        (rst_n),
    .pt_ctl       (pt_ctl),
    .pt_x         (pt_x),
    .pt_y         (pt_y),
    .image_width  (width_r),
    .image_height (height_r),
    .out_pop      (out_pop),
    .out_item     (out_item),
    .out_empty    (out_empty)
  );

  assign out_pixel_column = out_item.col;
  assign out_pixel_row    = out_item.row;
  assign out_inside_res   = out_item.in_frame;
  assign out_chosen_map   = out_item.map;

endmodule
